@@ src/sha256_pkg.sv @@
// Package for the SHA-256 stream hasher: sequencer states, round constants,
// initial hash words, padding constants and a rotate-right helper function.
// No dependencies.
package sha256_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_PADLEN,
    ST_EMIT
  } state_e;

  typedef logic [31:0] word_t;

  localparam word_t IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  function automatic word_t rotr(input word_t v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic word_t round_k(input logic [5:0] r);
    word_t k;
    unique case (r)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      6'd63: k = 32'hc67178f2;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

@@ src/sha256_stream_hasher.sv @@
// SHA-256 stream hasher top level: message schedule window that also collects
// the block bytes, one shared round unit and the block sequencer. Depends on sha256_pkg.
//
// channel  | dir | tdata               | tuser      | tlast
// s_axis   | in  | [7:0] data_byte     | byte_valid | message_end
// m_axis   | out | [31:0] digest_word  | -          | word_last
//
// A byte transaction that completes a block starts its processing (load, 64
// rounds through the single round unit, add); no byte is taken meanwhile.
// Message end costs one or two padded blocks, then eight digest transactions.
// s_axis_tready is high only while idle; m_axis stalls hold the digest word.
// Reset loads the initial hash words and clears counters and the sequencer.
module sha256_stream_hasher
  import sha256_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // byte_valid
  input  logic        s_axis_tlast,   // message_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic        m_axis_tlast    // word_last
);

  state_e      state_q, state_d;
  word_t       cv_q [8];
  word_t       win_q [16];
  word_t       reg_q [8];
  logic [5:0]  fill_q;
  logic [60:0] total_q;
  logic [5:0]  round_q;
  logic [2:0]  word_q;
  logic        end_q, pad_done_q, len_done_q;

  logic        s_hs, m_hs, wrap, pad_len;
  logic [63:0] bit_len;
  word_t       w_new, t1, t2;
  word_t       pad_blk [16];

  assign s_hs    = s_axis_tvalid & s_axis_tready;
  assign m_hs    = m_axis_tvalid & m_axis_tready;
  assign wrap    = s_axis_tuser && (fill_q == 6'd63);
  assign bit_len = {total_q, 3'b000};
  assign pad_len = (state_q == ST_PADLEN) || (fill_q < LEN_POS);

  assign w_new = win_q[0] + win_q[9]
               + (rotr(win_q[1], 7) ^ rotr(win_q[1], 18) ^ (win_q[1] >> 3))
               + (rotr(win_q[14], 17) ^ rotr(win_q[14], 19) ^ (win_q[14] >> 10));
  assign t1 = reg_q[7] + (rotr(reg_q[4], 6) ^ rotr(reg_q[4], 11) ^ rotr(reg_q[4], 25))
            + ((reg_q[4] & reg_q[5]) ^ (~reg_q[4] & reg_q[6]))
            + round_k(round_q) + win_q[0];
  assign t2 = (rotr(reg_q[0], 2) ^ rotr(reg_q[0], 13) ^ rotr(reg_q[0], 22))
            + ((reg_q[0] & reg_q[1]) ^ (reg_q[0] & reg_q[2]) ^ (reg_q[1] & reg_q[2]));

  always_comb begin
    int pos;
    for (int i = 0; i < 16; i++) begin
      for (int j = 0; j < 4; j++) begin
        pos = 4 * i + j;
        if (pad_len && (pos >= 56)) begin
          pad_blk[i][31-8*j -: 8] = bit_len[63-8*(pos-56) -: 8];
        end else if ((state_q == ST_PADLEN) || (6'(pos) > fill_q)) begin
          pad_blk[i][31-8*j -: 8] = '0;
        end else if (6'(pos) == fill_q) begin
          pad_blk[i][31-8*j -: 8] = PAD_BYTE;
        end else begin
          pad_blk[i][31-8*j -: 8] = win_q[i][31-8*j -: 8];
        end
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_hs) begin
          if (wrap) state_d = ST_START;
          else if (s_axis_tlast) state_d = ST_PAD;
        end
      end
      ST_START: state_d = ST_ROUND;
      ST_ROUND: begin
        if (round_q == 6'd63) state_d = ST_ADD;
      end
      ST_ADD: begin
        if (!end_q) state_d = ST_IDLE;
        else if (!pad_done_q) state_d = ST_PAD;
        else if (!len_done_q) state_d = ST_PADLEN;
        else state_d = ST_EMIT;
      end
      ST_PAD:    state_d = ST_START;
      ST_PADLEN: state_d = ST_START;
      ST_EMIT: begin
        if (m_hs && (word_q == 3'd7)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    m_axis_tvalid = (state_q == ST_EMIT);
    m_axis_tdata  = cv_q[word_q];
    m_axis_tlast  = (word_q == 3'd7);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cv_q       <= IV;
      fill_q     <= '0;
      total_q    <= '0;
      round_q    <= '0;
      word_q     <= '0;
      end_q      <= 1'b0;
      pad_done_q <= 1'b0;
      len_done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (s_hs) begin
        end_q <= s_axis_tlast;
        if (s_axis_tuser) begin
          fill_q  <= fill_q + 6'd1;
          total_q <= total_q + 61'd1;
        end
      end
      if (state_q == ST_START) round_q <= '0;
      if (state_q == ST_ROUND) round_q <= round_q + 6'd1;
      if (state_q == ST_ADD) begin
        for (int i = 0; i < 8; i++) cv_q[i] <= cv_q[i] + reg_q[i];
      end
      if (state_q == ST_PAD) begin
        pad_done_q <= 1'b1;
        if (fill_q < LEN_POS) len_done_q <= 1'b1;
      end
      if (state_q == ST_PADLEN) len_done_q <= 1'b1;
      if (m_hs) begin
        word_q <= word_q + 3'd1;
        if (word_q == 3'd7) begin
          cv_q       <= IV;
          fill_q     <= '0;
          total_q    <= '0;
          end_q      <= 1'b0;
          pad_done_q <= 1'b0;
          len_done_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_hs && s_axis_tuser) begin
      case (fill_q[1:0])
        2'd0: win_q[fill_q[5:2]][31:24] <= s_axis_tdata;
        2'd1: win_q[fill_q[5:2]][23:16] <= s_axis_tdata;
        2'd2: win_q[fill_q[5:2]][15:8]  <= s_axis_tdata;
        2'd3: win_q[fill_q[5:2]][7:0]   <= s_axis_tdata;
      endcase
    end
    if ((state_q == ST_PAD) || (state_q == ST_PADLEN)) win_q <= pad_blk;
    if (state_q == ST_START) reg_q <= cv_q;
    if (state_q == ST_ROUND) begin
      for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
      win_q[15] <= w_new;
      reg_q[7] <= reg_q[6];
      reg_q[6] <= reg_q[5];
      reg_q[5] <= reg_q[4];
      reg_q[4] <= reg_q[3] + t1;
      reg_q[3] <= reg_q[2];
      reg_q[2] <= reg_q[1];
      reg_q[1] <= reg_q[0];
      reg_q[0] <= t1 + t2;
    end
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input and output sides active together");

  a_last_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_hs && m_axis_tlast) |=> (s_axis_tready && (fill_q == 6'd0) && (cv_q[0] == IV[0])))
    else $error("no restart after final digest word");

  a_rounds_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND && round_q == 6'd63) |=> (state_q == ST_ADD))
    else $error("round sequence overran");

  a_emit_padded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (end_q && pad_done_q && len_done_q))
    else $error("digest emitted before padding finished");

endmodule

@@ tb/sha256_stream_hasher_test.sv @@
// Self-checking testbench for sha256_stream_hasher: streams messages byte by byte,
// predicts each digest in a scoreboard class and compares every output transaction.
// Depends on sha256_pkg and the RTL of sha256_stream_hasher.
`timescale 1ns / 1ps

module sha256_stream_hasher_test
  import sha256_pkg::*;
();

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } digest_beat_t;

  class digest_scoreboard;
    word_t        hash_words [8];
    logic [7:0]   block_bytes [64];
    logic [5:0]   fill;
    logic [60:0]  length_bytes;
    digest_beat_t pending_beats [$];
    int           mismatches;
    int           digests_seen;
    word_t        k_table [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function new();
      mismatches = 0;
      digests_seen = 0;
      restart();
    endfunction

    function void restart();
      hash_words = IV;
      fill = '0;
      length_bytes = '0;
    endfunction

    function word_t ror(word_t v, int n);
      return (v >> n) | (v << (32 - n));
    endfunction

    function void fold_block();
      word_t w [64];
      word_t a, b, c, d, e, f, g, h, t1, t2;
      for (int i = 0; i < 16; i++) begin
        w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
      end
      for (int i = 16; i < 64; i++) begin
        w[i] = w[i-16] + w[i-7]
             + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
             + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
      end
      {a, b, c, d, e, f, g, h} = {hash_words[0], hash_words[1], hash_words[2], hash_words[3],
                                  hash_words[4], hash_words[5], hash_words[6], hash_words[7]};
      for (int r = 0; r < 64; r++) begin
        t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) + k_table[r] + w[r];
        t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        h = g; g = f; f = e; e = d + t1;
        d = c; c = b; b = a; a = t1 + t2;
      end
      hash_words[0] += a; hash_words[1] += b; hash_words[2] += c; hash_words[3] += d;
      hash_words[4] += e; hash_words[5] += f; hash_words[6] += g; hash_words[7] += h;
    endfunction

    function void note_input(logic [7:0] data, logic byte_ok, logic ends);
      logic [63:0]  bit_len;
      logic [6:0]   idx;
      digest_beat_t beat;
      if (byte_ok) begin
        block_bytes[fill] = data;
        fill = fill + 6'd1;
        length_bytes = length_bytes + 61'd1;
        if (fill == 6'd0) fold_block();
      end
      if (!ends) return;
      bit_len = {length_bytes, 3'b000};
      idx = {1'b0, fill};
      block_bytes[idx[5:0]] = PAD_BYTE;
      idx = idx + 7'd1;
      while (idx != 7'd56) begin
        if (idx == 7'd64) begin
          fold_block();
          idx = '0;
        end
        block_bytes[idx[5:0]] = 8'h00;
        idx = idx + 7'd1;
      end
      for (int i = 0; i < 8; i++) block_bytes[56+i] = bit_len[63-8*i -: 8];
      fold_block();
      for (int i = 0; i < 8; i++) begin
        beat.word = hash_words[i];
        beat.last = (i == 7);
        pending_beats.push_back(beat);
      end
      restart();
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
    endtask

    task check_result(logic [31:0] word, logic last);
      digest_beat_t want;
      if (pending_beats.size() == 0) begin
        report($sformatf("unexpected digest word %08h", word));
        return;
      end
      want = pending_beats.pop_front();
      if (word !== want.word) report($sformatf("digest word %08h, want %08h", word, want.word));
      if (last !== want.last) report($sformatf("word_last %b, want %b", last, want.last));
      if (want.last) digests_seen++;
    endtask
  endclass

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLDOFF_CYCLES = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;

  digest_scoreboard sb = new();
  int sender_idle_pct = 34;
  int receiver_idle_pct = 70;
  logic holdoff_go = 1'b0;
  int holdoff_count = 0;
  int cycle_count = 0;
  int items_sent = 0;
  int bytes_sent = 0;

  sha256_stream_hasher dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("sha256_stream_hasher regression: fail");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (holdoff_go && (holdoff_count < HOLDOFF_CYCLES)) begin
      m_axis_tready = 1'b0;
      holdoff_count++;
    end else begin
      m_axis_tready = ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
  end

  task automatic send_item(logic [7:0] data, logic byte_ok, logic ends);
    while ($urandom_range(0, 99) < sender_idle_pct) @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = data;
    s_axis_tuser = byte_ok;
    s_axis_tlast = ends;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(data, byte_ok, ends);
    if (byte_ok) bytes_sent++;
    if (byte_ok || ends) items_sent++;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic send_message(int len);
    logic merge_end;
    merge_end = (len > 0) && $urandom_range(0, 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1, merge_end && (i == len - 1));
    end
    if (!merge_end) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic drain();
    while (sb.pending_beats.size() != 0) @(negedge clk_i);
  endtask

  function automatic int pick_length();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 55;
      2: return 56;
      3: return 63;
      4: return 64;
      5: return $urandom_range(100, 130);
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'ha5, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h3c, 1'b0, 1'b1);
    drain();

    do send_message(pick_length()); while (items_sent < 70);
    drain();
    sender_idle_pct = 70;
    receiver_idle_pct = 34;
    do send_message(pick_length()); while (items_sent < 140);
    drain();
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    holdoff_go = 1'b1;
    send_message(3);
    send_message(0);
    send_message(70);
    while (items_sent < 210) send_message(pick_length());
    drain();
    repeat (100) @(negedge clk_i);

    $display("streamed %0d bytes in %0d transactions, checked %0d digests",
             bytes_sent, items_sent, sb.digests_seen);
    if (sb.mismatches == 0) begin
      $display("sha256_stream_hasher regression: pass");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("sha256_stream_hasher regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/sha256_pkg.sv
src/sha256_stream_hasher.sv
tb/sha256_stream_hasher_test.sv
